// ===== rtl/core/emc_pkg.sv =====
// Package for the equal-mass circle collision response pipeline.
// Payload structs, internal widths and pipeline depth constants. No dependencies.
package emc_pkg;

  localparam int VelW   = 16;
  localparam int DiffW  = 18;
  localparam int DvW    = 17;
  localparam int AbsW   = 17;
  localparam int ProdW  = 35;
  localparam int MagPW  = 34;
  localparam int HalfW  = 17;
  localparam int NumW   = 52;
  localparam int DenW   = 35;
  localparam int QuoW   = 18;
  localparam int RemW   = 36;
  localparam int ResW   = 20;
  localparam int FrontStages = 6;
  localparam int DivStages   = QuoW;
  localparam int Latency     = FrontStages + DivStages + 1;

  typedef struct packed {
    logic [15:0]        pos1_x;
    logic [15:0]        pos1_y;
    logic [11:0]        radius1;
    logic [15:0]        pos2_x;
    logic [15:0]        pos2_y;
    logic [11:0]        radius2;
    logic signed [15:0] vel1_x;
    logic signed [15:0] vel1_y;
    logic signed [15:0] vel2_x;
    logic signed [15:0] vel2_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] new_vel1_x;
    logic signed [15:0] new_vel1_y;
    logic signed [15:0] new_vel2_x;
    logic signed [15:0] new_vel2_y;
    logic               centres_coincide;
    logic               saturated;
  } out_t;

  // travels beside the dividers
  typedef struct packed {
    logic signed [15:0] vel1_x;
    logic signed [15:0] vel1_y;
    logic signed [15:0] vel2_x;
    logic signed [15:0] vel2_y;
    logic               coincide;
    logic               neg_x;
    logic               neg_y;
  } side_t;

  typedef struct packed {
    logic            valid;
    side_t           side;
    logic [NumW-1:0] num_x;
    logic [NumW-1:0] num_y;
    logic [DenW-1:0] den;
  } front_t;

endpackage

// ===== rtl/core/emc_front.sv =====
// Front pipeline: centres, differences, dot product, squared length, numerators.
// Six register stages. Depends on emc_pkg.
module emc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  emc_pkg::in_t  in_data,
  output emc_pkg::front_t front
);
  import emc_pkg::*;

  logic [FrontStages-1:0] v_r;
  logic signed [VelW-1:0] v1x_r[0:5], v1y_r[0:5], v2x_r[0:5], v2y_r[0:5];

  // stage 1
  logic signed [DiffW-1:0] dx_r, dy_r;
  logic signed [DvW-1:0]   dvx_r, dvy_r;
  // stage 2
  logic signed [ProdW-1:0] mx_r, my_r, sx_r, sy_r;
  logic [AbsW-1:0]         adx_r[0:3], ady_r[0:3];
  logic                    ndx_r[0:3], ndy_r[0:3];
  logic                    coin_r[0:4];
  // stage 3
  logic signed [ProdW-1:0] p_r;
  logic [MagPW-1:0]        l2_r[0:2];
  // stage 4
  logic [MagPW-1:0]        ap_r;
  logic                    np_r;
  // stage 5
  logic [MagPW-1:0]        lox_r, hix_r, loy_r, hiy_r;
  logic                    negx_r, negy_r;
  // stage 6
  logic [NumW-1:0]         numx_r, numy_r;
  logic [DenW-1:0]         den_r;
  logic                    negx6_r, negy6_r;

  logic [AbsW-1:0] c1x, c1y, c2x, c2y;
  logic [NumW-1:0] magx, magy;

  assign c1x = AbsW'(in_data.pos1_x) + AbsW'(in_data.radius1);
  assign c1y = AbsW'(in_data.pos1_y) + AbsW'(in_data.radius1);
  assign c2x = AbsW'(in_data.pos2_x) + AbsW'(in_data.radius2);
  assign c2y = AbsW'(in_data.pos2_y) + AbsW'(in_data.radius2);

  assign magx = NumW'(lox_r) + (NumW'(hix_r) << HalfW);
  assign magy = NumW'(loy_r) + (NumW'(hiy_r) << HalfW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FrontStages-2:0], in_valid};
    end
    // stage 1
    dx_r  <= $signed({1'b0, c2x}) - $signed({1'b0, c1x});
    dy_r  <= $signed({1'b0, c2y}) - $signed({1'b0, c1y});
    dvx_r <= DvW'(in_data.vel1_x) - DvW'(in_data.vel2_x);
    dvy_r <= DvW'(in_data.vel1_y) - DvW'(in_data.vel2_y);
    v1x_r[0] <= in_data.vel1_x;
    v1y_r[0] <= in_data.vel1_y;
    v2x_r[0] <= in_data.vel2_x;
    v2y_r[0] <= in_data.vel2_y;
    for (int i = 1; i < 6; i++) begin
      v1x_r[i] <= v1x_r[i-1];
      v1y_r[i] <= v1y_r[i-1];
      v2x_r[i] <= v2x_r[i-1];
      v2y_r[i] <= v2y_r[i-1];
    end
    // stage 2
    mx_r <= ProdW'(dx_r) * ProdW'(dvx_r);
    my_r <= ProdW'(dy_r) * ProdW'(dvy_r);
    sx_r <= ProdW'(dx_r) * ProdW'(dx_r);
    sy_r <= ProdW'(dy_r) * ProdW'(dy_r);
    adx_r[0] <= dx_r[DiffW-1] ? AbsW'(-dx_r) : AbsW'(dx_r);
    ady_r[0] <= dy_r[DiffW-1] ? AbsW'(-dy_r) : AbsW'(dy_r);
    ndx_r[0] <= dx_r[DiffW-1];
    ndy_r[0] <= dy_r[DiffW-1];
    coin_r[0] <= (dx_r == '0) && (dy_r == '0);
    for (int i = 1; i < 4; i++) begin
      adx_r[i] <= adx_r[i-1];
      ady_r[i] <= ady_r[i-1];
      ndx_r[i] <= ndx_r[i-1];
      ndy_r[i] <= ndy_r[i-1];
    end
    for (int i = 1; i < 5; i++) begin
      coin_r[i] <= coin_r[i-1];
    end
    // stage 3
    p_r      <= mx_r + my_r;
    l2_r[0]  <= sx_r[MagPW-1:0] + sy_r[MagPW-1:0];
    l2_r[1]  <= l2_r[0];
    l2_r[2]  <= l2_r[1];
    // stage 4
    ap_r <= p_r[ProdW-1] ? MagPW'(-p_r) : MagPW'(p_r);
    np_r <= p_r[ProdW-1];
    // stage 5: split product of 17 by 34 bits
    lox_r  <= MagPW'(adx_r[2]) * MagPW'(ap_r[HalfW-1:0]);
    hix_r  <= MagPW'(adx_r[2]) * MagPW'(ap_r[MagPW-1:HalfW]);
    loy_r  <= MagPW'(ady_r[2]) * MagPW'(ap_r[HalfW-1:0]);
    hiy_r  <= MagPW'(ady_r[2]) * MagPW'(ap_r[MagPW-1:HalfW]);
    negx_r <= ndx_r[2] ^ np_r;
    negy_r <= ndy_r[2] ^ np_r;
    // stage 6: rounding numerator 2*mag + l2 over denominator 2*l2
    numx_r  <= (magx << 1) + NumW'(l2_r[2]);
    numy_r  <= (magy << 1) + NumW'(l2_r[2]);
    den_r   <= {l2_r[2], 1'b0};
    negx6_r <= negx_r;
    negy6_r <= negy_r;
  end

  assign front.valid         = v_r[FrontStages-1];
  assign front.side.vel1_x   = v1x_r[5];
  assign front.side.vel1_y   = v1y_r[5];
  assign front.side.vel2_x   = v2x_r[5];
  assign front.side.vel2_y   = v2y_r[5];
  assign front.side.coincide = coin_r[4];
  assign front.side.neg_x    = negx6_r;
  assign front.side.neg_y    = negy6_r;
  assign front.num_x         = numx_r;
  assign front.num_y         = numy_r;
  assign front.den           = den_r;

endmodule

// ===== rtl/core/emc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Quotient known to fit QuoW bits. Depends on emc_pkg.
module emc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [emc_pkg::NumW-1:0]     num,
  input  logic [emc_pkg::DenW-1:0]     den,
  output logic                         out_valid,
  output logic [emc_pkg::QuoW-1:0]     quo
);
  import emc_pkg::*;

  localparam int LowW = NumW - QuoW - (NumW - QuoW - QuoW);

  logic [DivStages-1:0] v_r;
  logic [RemW-1:0]      rem_r[0:DivStages-1];
  logic [QuoW-1:0]      low_r[0:DivStages-1];
  logic [QuoW-1:0]      q_r[0:DivStages-1];
  logic [DenW-1:0]      den_r[0:DivStages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DivStages-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < DivStages; i++) begin : g_stage
    logic [RemW-1:0] rem_in, trial;
    logic [QuoW-1:0] low_in, q_in;
    logic [DenW-1:0] den_in;
    logic            take;
    if (i == 0) begin : g_first
      assign rem_in = RemW'(num[NumW-1:LowW]);
      assign low_in = num[LowW-1:0];
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign q_in   = q_r[i-1];
      assign den_in = den_r[i-1];
    end
    assign trial = {rem_in[RemW-2:0], low_in[QuoW-1]};
    assign take  = trial >= RemW'(den_in);
    always_ff @(posedge clk) begin
      rem_r[i] <= take ? trial - RemW'(den_in) : trial;
      low_r[i] <= {low_in[QuoW-2:0], 1'b0};
      q_r[i]   <= {q_in[QuoW-2:0], take};
      den_r[i] <= den_in;
    end
  end

  assign out_valid = v_r[DivStages-1];
  assign quo       = q_r[DivStages-1];

endmodule

// ===== rtl/core/emc_back.sv =====
// Output stage: applies the exchange term, saturates, registers the result.
// Depends on emc_pkg.
module emc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  emc_pkg::side_t           side,
  input  logic [emc_pkg::QuoW-1:0] qx,
  input  logic [emc_pkg::QuoW-1:0] qy,
  output logic                     out_valid,
  output emc_pkg::out_t            out_data
);
  import emc_pkg::*;

  logic signed [QuoW:0]   ex, ey;
  logic signed [ResW-1:0] r1x, r1y, r2x, r2y;
  logic [3:0]             hit;
  logic signed [VelW-1:0] c1x, c1y, c2x, c2y;
  logic                   valid_r;
  out_t                   out_r;

  function automatic logic signed [VelW-1:0] clamp(input logic signed [ResW-1:0] v);
    logic signed [VelW-1:0] res;
    if (v > ResW'(32767)) res = 16'sh7fff;
    else if (v < -ResW'(32768)) res = 16'sh8000;
    else res = v[VelW-1:0];
    return res;
  endfunction

  function automatic logic over(input logic signed [ResW-1:0] v);
    return (v > ResW'(32767)) || (v < -ResW'(32768));
  endfunction

  assign ex  = side.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign ey  = side.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign r1x = ResW'(side.vel1_x) - ResW'(ex);
  assign r1y = ResW'(side.vel1_y) - ResW'(ey);
  assign r2x = ResW'(side.vel2_x) + ResW'(ex);
  assign r2y = ResW'(side.vel2_y) + ResW'(ey);
  assign hit = {over(r1x), over(r1y), over(r2x), over(r2y)};
  assign c1x = clamp(r1x);
  assign c1y = clamp(r1y);
  assign c2x = clamp(r2x);
  assign c2y = clamp(r2y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    out_r.new_vel1_x       <= side.coincide ? side.vel1_x : c1x;
    out_r.new_vel1_y       <= side.coincide ? side.vel1_y : c1y;
    out_r.new_vel2_x       <= side.coincide ? side.vel2_x : c2x;
    out_r.new_vel2_y       <= side.coincide ? side.vel2_y : c2y;
    out_r.centres_coincide <= side.coincide;
    out_r.saturated        <= !side.coincide && (hit != '0);
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/equal_mass_circle_collision_response_top.sv =====
// Top level of the equal-mass circle collision response pipeline.
// Instantiates emc_front, two emc_div and emc_back. Depends on emc_pkg.
//
// One transaction is taken in every cycle; busy is always low. Each result
// appears on out_valid after six front stages (centres, products, split
// multiply of the normal term), an 18-stage restoring divider per axis
// giving one quotient bit per stage, and one output register for
// saturation. Results come out in order and must be taken the cycle they
// are shown; the receiver cannot stall the pipeline.
module equal_mass_circle_collision_response_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  emc_pkg::in_t   in_data,
  output logic           out_valid,
  output emc_pkg::out_t  out_data
);
  import emc_pkg::*;

  front_t          front;
  logic            dvx, dvy;
  logic [QuoW-1:0] qx, qy;
  side_t           side_r[0:DivStages-1];

  assign busy = 1'b0;

  emc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_data  (in_data),
    .front    (front)
  );

  emc_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front.valid),
    .num       (front.num_x),
    .den       (front.den),
    .out_valid (dvx),
    .quo       (qx)
  );

  emc_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front.valid),
    .num       (front.num_y),
    .den       (front.den),
    .out_valid (dvy),
    .quo       (qy)
  );

  always_ff @(posedge clk) begin
    side_r[0] <= front.side;
    for (int i = 1; i < DivStages; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  emc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dvx && dvy),
    .side      (side_r[DivStages-1]),
    .qx        (qx),
    .qy        (qy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Latency))
    else $error("result without matching transaction");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dvx == dvy)
    else $error("dividers out of step");

  a_coincide_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.centres_coincide |->
      !out_data.saturated && out_data.new_vel1_x == $past(in_data.vel1_x, Latency))
    else $error("coincident centres altered velocity");

endmodule

// ===== test/emc_collision_checker.sv =====
`timescale 1ns / 100ps
// Checker for the equal-mass circle collision response block: watches the
// start and result channels, predicts each result and compares. Uses emc_pkg.
module emc_collision_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  emc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  emc_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count
);
  import emc_pkg::*;

  out_t expected_q[$];

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_vel(longint v, ref bit sat);
    if (v > 32767) begin
      sat = 1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1;
      return -32768;
    end
    return v;
  endfunction

  function automatic out_t collide(in_t t);
    out_t r;
    longint dx, dy, a1x, a1y, a2x, a2y, l2, p, ex, ey;
    bit sat;
    sat = 0;
    a1x = t.vel1_x;
    a1y = t.vel1_y;
    a2x = t.vel2_x;
    a2y = t.vel2_y;
    dx = (longint'(t.pos2_x) + t.radius2) - (longint'(t.pos1_x) + t.radius1);
    dy = (longint'(t.pos2_y) + t.radius2) - (longint'(t.pos1_y) + t.radius1);
    r.centres_coincide = (dx == 0 && dy == 0);
    if (r.centres_coincide) begin
      r.new_vel1_x = t.vel1_x;
      r.new_vel1_y = t.vel1_y;
      r.new_vel2_x = t.vel2_x;
      r.new_vel2_y = t.vel2_y;
    end else begin
      l2 = dx * dx + dy * dy;
      p = dx * (a1x - a2x) + dy * (a1y - a2y);
      ex = round_div(dx * p, l2);
      ey = round_div(dy * p, l2);
      r.new_vel1_x = 16'(clamp_vel(a1x - ex, sat));
      r.new_vel1_y = 16'(clamp_vel(a1y - ey, sat));
      r.new_vel2_x = 16'(clamp_vel(a2x + ex, sat));
      r.new_vel2_y = 16'(clamp_vel(a2y + ey, sat));
    end
    r.saturated = sat;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    out_t e;
    int errs;
    errs = 0;
    if (rst_n && start && !busy) expected_q = {expected_q, collide(in_data)};
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errs = errs + 1;
      end else begin
        e = expected_q.pop_front();
        if (out_data.new_vel1_x !== e.new_vel1_x) begin
          $error("new_vel1_x exp %0d got %0d", e.new_vel1_x, out_data.new_vel1_x);
          errs = errs + 1;
        end
        if (out_data.new_vel1_y !== e.new_vel1_y) begin
          $error("new_vel1_y exp %0d got %0d", e.new_vel1_y, out_data.new_vel1_y);
          errs = errs + 1;
        end
        if (out_data.new_vel2_x !== e.new_vel2_x) begin
          $error("new_vel2_x exp %0d got %0d", e.new_vel2_x, out_data.new_vel2_x);
          errs = errs + 1;
        end
        if (out_data.new_vel2_y !== e.new_vel2_y) begin
          $error("new_vel2_y exp %0d got %0d", e.new_vel2_y, out_data.new_vel2_y);
          errs = errs + 1;
        end
        if (out_data.centres_coincide !== e.centres_coincide) begin
          $error("centres_coincide exp %0b got %0b", e.centres_coincide,
                 out_data.centres_coincide);
          errs = errs + 1;
        end
        if (out_data.saturated !== e.saturated) begin
          $error("saturated exp %0b got %0b", e.saturated, out_data.saturated);
          errs = errs + 1;
        end
      end
    end
    fail_count <= fail_count + errs;
    pending_count <= expected_q.size();
  end
endmodule

// ===== test/equal_mass_circle_collision_response_top_test.sv =====
`timescale 1ns / 100ps
// Testbench top for equal_mass_circle_collision_response_top: drives directed
// and random circle pairs, gives the verdict. Uses emc_pkg, emc_collision_checker.
module equal_mass_circle_collision_response_top_test;
  import emc_pkg::*;

  localparam int RandomItems = 1250;
  localparam longint CycleLimit = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;
  int fail_count;
  int pending_count;
  longint cycle_count;

  equal_mass_circle_collision_response_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  emc_collision_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("equal_mass_circle_collision_response_top test failed");
      $finish;
    end
  end

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 200)) - 16'd100;
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rand_pair();
    in_t t;
    t.pos1_x = 16'($urandom);
    t.pos1_y = 16'($urandom);
    t.radius1 = 12'($urandom);
    t.radius2 = 12'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        t.pos2_x = t.pos1_x + 16'($urandom_range(0, 64)) - 16'd32;
        t.pos2_y = t.pos1_y + 16'($urandom_range(0, 64)) - 16'd32;
      end
      1: begin
        // same centre unless the 16-bit position wraps, or one unit apart in y
        t.pos2_x = t.pos1_x + t.radius1 - t.radius2;
        t.pos2_y = t.pos1_y + t.radius1 - t.radius2;
        if ($urandom_range(0, 1)) t.pos2_y = t.pos2_y + 1;
      end
      default: begin
        t.pos2_x = 16'($urandom);
        t.pos2_y = 16'($urandom);
      end
    endcase
    t.vel1_x = rand_vel();
    t.vel1_y = rand_vel();
    t.vel2_x = rand_vel();
    t.vel2_y = rand_vel();
    return t;
  endfunction

  task automatic send_pair(in_t t);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_data <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drain();
    start <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic send_directed(logic [15:0] p1x, logic [15:0] p1y, logic [11:0] r1,
                               logic [15:0] p2x, logic [15:0] p2y, logic [11:0] r2,
                               logic [15:0] a1x, logic [15:0] a1y,
                               logic [15:0] a2x, logic [15:0] a2y);
    in_t t;
    t = '{p1x, p1y, r1, p2x, p2y, r2, a1x, a1y, a2x, a2y};
    send_pair(t);
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_directed(0, 0, 0, 0, 0, 0, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_directed(100, 100, 10, 90, 90, 20, 500, 500, -500, -500);
    send_directed(0, 0, 0, 16'hffff, 16'hffff, 12'hfff, 16'h7fff, 16'h7fff,
                  16'h8000, 16'h8000);
    send_directed(16'hffff, 16'hffff, 12'hfff, 0, 0, 0, 16'h8000, 16'h8000,
                  16'h7fff, 16'h7fff);
    send_directed(0, 0, 0, 16, 0, 0, 16'h7fff, 0, 16'h8000, 0);
    send_directed(0, 0, 0, 0, 16, 0, 0, 16'h8000, 0, 16'h7fff);
    send_directed(0, 0, 0, 1, 0, 0, 256, 0, 0, 0);
    send_directed(0, 0, 0, 1, 1, 0, 256, 0, 0, 0);
    send_directed(0, 0, 0, 1, 2, 0, 1, 0, 0, 0);
    send_directed(0, 0, 0, 2, 1, 0, 1, 1, 0, 0);
    send_directed(0, 0, 0, 3, 0, 0, 16'h7fff, 300, 16'h8000, -300);
    send_directed(50, 0, 0, 0, 50, 0, 100, 100, 100, 100);
    send_directed(0, 0, 12'hfff, 0, 0, 12'hfff, 7, -7, 3, -3);
    send_directed(16'haaaa, 16'h5555, 12'ha5a, 16'h5555, 16'haaaa, 12'h5a5,
                  16'haaaa, 16'h5555, 16'h5555, 16'haaaa);
    wait_drain();
    for (int i = 0; i < RandomItems; i++) begin
      send_pair(rand_pair());
      if (i == RandomItems / 2) begin
        wait_drain();
      end
    end
    wait_drain();
    repeat (Latency + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("equal_mass_circle_collision_response_top test passed");
    end else begin
      $display("equal_mass_circle_collision_response_top test failed");
    end
    $finish;
  end
endmodule
